[rtl/mnst_pkg.sv]
`default_nettype none
package mnst_pkg;

  localparam int NOTE_COUNT = 256;
  localparam int IDX_W = $clog2(NOTE_COUNT);

  // item opcodes
  localparam logic [1:0] OP_MESSAGE = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  // upper nibble of the midi status byte
  localparam logic [3:0] NIBBLE_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIBBLE_NOTE_ON  = 4'h9;

  typedef struct packed {
    logic [7:0] vel;
    logic       release_ack;
    logic       press_ack;
    logic       released;
    logic       held;
    logic       pressed;
  } note_entry_t;

  localparam int ENTRY_W = $bits(note_entry_t);

  typedef struct packed {
    logic capture;
    logic msg_write;
    logic rd_en;
    logic tick_rd;
    logic tick_write;
    logic cnt_clr;
    logic cnt_inc;
    logic out_load;
  } mnst_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       cnt_zero;
    logic       cnt_last;
    logic       out_free;
  } mnst_status_t;

  // one frame step on an entry, first matching rule wins
  function automatic note_entry_t tick_entry(input note_entry_t e);
    note_entry_t r;
    r = e;
    if (e.press_ack) begin
      r.pressed = 1'b0;
    end else if (e.release_ack) begin
      r.released = 1'b0;
    end else if (e.pressed) begin
      r.press_ack = 1'b1;
    end else if (e.released) begin
      r.release_ack = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/mnst_if.sv]
`default_nettype none
interface mnst_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] status;
  logic [7:0] note;
  logic [7:0] velocity;

  modport source (output valid, opcode, status, note, velocity, input ready);
  modport sink (input valid, opcode, status, note, velocity, output ready);
endinterface

interface mnst_result_if;
  logic       valid;
  logic       ready;
  logic       pressed;
  logic       held;
  logic       released;
  logic [7:0] note_velocity;

  modport source (output valid, pressed, held, released, note_velocity, input ready);
  modport sink (input valid, pressed, held, released, note_velocity, output ready);
endinterface
`default_nettype wire

[rtl/mnst_ram.sv]
`default_nettype none
module mnst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/mnst_datapath.sv]
`default_nettype none
module mnst_datapath import mnst_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire mnst_cmd_t    cmd,
  output mnst_status_t      st,
  input  wire logic [1:0]   opcode,
  input  wire logic [7:0]   status,
  input  wire logic [7:0]   note,
  input  wire logic [7:0]   velocity,
  input  wire logic         out_ready,
  output logic              out_valid,
  output logic              pressed,
  output logic              held,
  output logic              released,
  output logic [7:0]        note_velocity
);

  logic [1:0]            opcode_q;
  logic [3:0]            nibble_q;
  logic [7:0]            note_q;
  logic [7:0]            vel_q;
  logic [IDX_W-1:0]      cnt;
  logic [IDX_W-1:0]      wb_addr;
  logic [NOTE_COUNT-1:0] vld;
  logic                  vld_q;

  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] wdata;
  logic [IDX_W-1:0]   waddr;
  logic               we;
  logic               in_range;
  logic               msg_ok;
  note_entry_t        cur;
  note_entry_t        msg_entry;

  // captured request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      opcode_q <= opcode;
      nibble_q <= status[7:4];
      note_q   <= note;
      vel_q    <= velocity;
    end
  end

  // frame walk counter and write-back address
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      wb_addr <= rd_addr;
      vld_q   <= vld[rd_addr];
    end
  end

  assign rd_addr  = cmd.tick_rd ? cnt : note_q[IDX_W-1:0];
  assign in_range = {1'b0, note_q} < 9'(NOTE_COUNT);
  assign cur      = vld_q ? note_entry_t'(rdata) : '0;

  always_comb begin
    msg_entry = '0;
    if (nibble_q == NIBBLE_NOTE_ON) begin
      msg_entry.pressed = 1'b1;
      msg_entry.held    = 1'b1;
      msg_entry.vel     = vel_q;
    end else begin
      msg_entry.released = 1'b1;
    end
  end

  assign msg_ok = cmd.msg_write && in_range &&
                  (nibble_q == NIBBLE_NOTE_OFF || nibble_q == NIBBLE_NOTE_ON);
  assign we     = msg_ok || cmd.tick_write;
  assign waddr  = cmd.tick_write ? wb_addr : note_q[IDX_W-1:0];
  assign wdata  = cmd.tick_write ? tick_entry(cur) : msg_entry;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  mnst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NOTE_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pressed       <= in_range & cur.pressed;
      held          <= in_range & cur.held;
      released      <= in_range & cur.released;
      note_velocity <= in_range ? cur.vel : 8'd0;
    end
  end

  assign st.opcode   = opcode_q;
  assign st.cnt_zero = (cnt == '0);
  assign st.cnt_last = (cnt == IDX_W'(NOTE_COUNT - 1));
  assign st.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

[rtl/mnst_ctrl.sv]
`default_nettype none
module mnst_ctrl import mnst_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire mnst_status_t st,
  output mnst_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_TICK     = 3'd2;
  localparam logic [2:0] S_TICK_END = 3'd3;
  localparam logic [2:0] S_QOUT     = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.opcode)
          OP_MESSAGE: begin
            cmd.msg_write = 1'b1;
            state_next    = S_IDLE;
          end
          OP_TICK: begin
            cmd.cnt_clr = 1'b1;
            state_next  = S_TICK;
          end
          OP_QUERY: begin
            cmd.rd_en  = 1'b1;
            state_next = S_QOUT;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_TICK: begin
        // read entry n while writing back entry n-1
        cmd.rd_en      = 1'b1;
        cmd.tick_rd    = 1'b1;
        cmd.cnt_inc    = 1'b1;
        cmd.tick_write = !st.cnt_zero;
        if (st.cnt_last) begin
          state_next = S_TICK_END;
        end
      end
      S_TICK_END: begin
        cmd.tick_write = 1'b1;
        state_next     = S_IDLE;
      end
      S_QOUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/midi_note_state_tracker_top.sv]
// channel  dir  payload                                     handshake
// item     in   opcode, status, note, velocity              valid/ready
// result   out  pressed, held, released, note_velocity      valid/ready
//
// one request at a time; a message is written in the decode state, then the next accept follows
// a query reads the ram, then loads the result register once the sink has freed it
// a frame tick makes one pass over the note ram, one entry
//   per cycle, read of entry n overlapped with write-back of entry n-1
// rst is synchronous; it clears the per-entry valid flops, so every note reads
//   as zero at once and no clearing pass is needed
// result stalls hold the result register; a new request is still taken meanwhile
`default_nettype none
module midi_note_state_tracker_top import mnst_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  mnst_item_if.sink     item,
  mnst_result_if.source result
);

  mnst_cmd_t    cmd;
  mnst_status_t st;

  // sequencer: accept, decode, walk the store on frame ticks, hand off query results
  mnst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // request capture, note ram with valid flops, frame update, result register
  mnst_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .opcode        (item.opcode),
    .status        (item.status),
    .note          (item.note),
    .velocity      (item.velocity),
    .out_ready     (result.ready),
    .out_valid     (result.valid),
    .pressed       (result.pressed),
    .held          (result.held),
    .released      (result.released),
    .note_velocity (result.note_velocity)
  );

endmodule
`default_nettype wire

[rtl/mnst_checker.sv]
`default_nettype none
module mnst_checker import mnst_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       item_valid,
  input wire logic       item_ready,
  input wire logic       result_valid,
  input wire logic       result_ready,
  input wire logic       result_pressed,
  input wire logic       result_held,
  input wire logic       result_released,
  input wire logic [7:0] result_note_velocity
);

  // stalled result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(result_pressed) && $stable(result_held) &&
      $stable(result_released) && $stable(result_note_velocity))
    else $error("stalled result changed");

  // one request in flight: no accept right after an accept
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("request taken while busy");

  // a result never appears the cycle after a request is taken
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !$rose(result_valid))
    else $error("result too early");

  // reset empties the result register
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind midi_note_state_tracker_top mnst_checker u_chk (
  .clk                  (clk),
  .rst                  (rst),
  .item_valid           (item.valid),
  .item_ready           (item.ready),
  .result_valid         (result.valid),
  .result_ready         (result.ready),
  .result_pressed       (result.pressed),
  .result_held          (result.held),
  .result_released      (result.released),
  .result_note_velocity (result.note_velocity)
);
`default_nettype wire
